// ===== hdl/cbts_pkg.sv =====
// Shared types, constants and helper functions for the CAN bit timing solver.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package cbts_pkg;

	localparam int unsigned MAX_QUANTA_DEF    = 25;
	localparam int unsigned MIN_QUANTA_DEF    = 5;
	localparam int unsigned MAX_PRESCALER_DEF = 256;

	localparam int unsigned CLK_W     = 28;
	localparam int unsigned DIV_W     = 7;
	localparam int unsigned RATE_W    = 20;
	localparam int unsigned TOL_W     = 20;
	localparam int unsigned TQ_W      = 5;
	localparam int unsigned ACC_W     = 64;
	localparam int unsigned D_W       = 32;
	localparam int unsigned MUL_B_W   = 20;
	localparam int unsigned MUL_CNT_W = 5;
	localparam int unsigned DIV_CNT_W = 7;
	localparam int unsigned DR_W      = DIV_W + RATE_W;
	localparam int unsigned SPNUM_W   = 12;

	localparam logic [CLK_W-1:0]   CLK_RESET       = 28'd60000000;
	localparam logic [DIV_W-1:0]   DIV_RESET       = 7'd1;
	localparam logic [MUL_B_W-1:0] PPM_SCALE       = 20'd1000000;
	localparam logic [RATE_W-1:0]  TRIPLE_RATE_MAX = 20'd125000;
	localparam int unsigned        PSC_LIMIT       = 256;
	localparam logic [TQ_W-1:0]    SEG_LIMIT       = 5'd8;
	localparam logic [TQ_W-1:0]    RJW_LIMIT       = 5'd4;

	localparam logic [DIV_CNT_W-1:0] ITER_CLK = 7'd28;
	localparam logic [DIV_CNT_W-1:0] ITER_PPM = 7'd64;
	localparam logic [DIV_CNT_W-1:0] ITER_SP  = 7'd12;

	localparam int unsigned REG_CLOCK_FREQUENCY = 0;
	localparam int unsigned REG_CLOCK_DIVISOR   = 1;

	typedef enum logic [3:0] {
		OP_DR, OP_D0, OP_SRCH, OP_W, OP_LHS, OP_RHS, OP_WDV, OP_DVP, OP_DVPT,
		OP_ACT, OP_PPM, OP_SP
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_GO, ST_WAIT, ST_CHECK, ST_DONE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic start;
		op_t  op;
		logic check;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic stop;
	} status_t;

	function automatic logic is_div_op(input op_t op);
		logic r;
		case (op)
			OP_SRCH, OP_ACT, OP_PPM, OP_SP: r = 1'b1;
			default:                        r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic op_t next_op(input op_t op);
		op_t r;
		unique case (op)
			OP_DR:   r = OP_D0;
			OP_D0:   r = OP_SRCH;
			OP_W:    r = OP_LHS;
			OP_LHS:  r = OP_RHS;
			OP_RHS:  r = OP_WDV;
			OP_WDV:  r = OP_DVP;
			OP_DVP:  r = OP_DVPT;
			OP_DVPT: r = OP_ACT;
			OP_ACT:  r = OP_PPM;
			OP_PPM:  r = OP_SP;
			default: r = OP_SP;
		endcase
		return r;
	endfunction

	// Floor of x / 7 for x up to 50, by multiplying with 37 / 256.
	function automatic logic [TQ_W-1:0] div7(input logic [5:0] x);
		logic [11:0] p;
		p = {6'b0, x} * 12'd37;
		return {2'b0, p[10:8]};
	endfunction

endpackage

// ===== hdl/can_bit_timing_solver.sv =====
// CAN bit timing solver.
// An input beat carries wished_rate (bit/s) and tolerance_ppm. The block searches
// quanta counts from MAX_QUANTA down to MIN_QUANTA for the prescaler with the least
// clock error and returns one result beat with prescaler, segment lengths, jump
// width, triple sampling, tolerance check, actual rate, ppm error, sample point and
// consistency flags. clock_frequency (address 0) and clock_divisor (address 4) are
// to be written over the APB port only while the block is idle; it does not enforce this.
// Each search step is one pass of the serial divider plus control, up to 21 steps; eight
// passes of the serial multiplier and three divider passes make up the rest. One item
// is worked on at a time.
// The next input beat is taken as soon as the sequencer is idle, even while the
// previous result still waits in the output register. A stalled result holds; the
// solver then waits after finishing until that beat has gone.
// Reset empties the block, clears out_valid and loads clock_frequency = 60 MHz and
// clock_divisor = 1.
// Depends on cbts_pkg, cbts_ctrl and cbts_datapath.
`timescale 1ns / 1ps

module can_bit_timing_solver
	import cbts_pkg::*;
#(
	parameter int unsigned MAX_QUANTA    = MAX_QUANTA_DEF,
	parameter int unsigned MIN_QUANTA    = MIN_QUANTA_DEF,
	parameter int unsigned MAX_PRESCALER = MAX_PRESCALER_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [RATE_W-1:0] wished_rate,
	input  logic [TOL_W-1:0]  tolerance_ppm,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [8:0]        prescaler,
	output logic [3:0]        prop_segment,
	output logic [3:0]        phase_one,
	output logic [3:0]        phase_two,
	output logic [2:0]        jump_width,
	output logic              triple_sample,
	output logic              within_tolerance,
	output logic [25:0]       actual_rate,
	output logic              exact_match,
	output logic [31:0]       ppm_error,
	output logic [6:0]        sample_point_pct,
	output logic [11:0]       consistency_flags
);

	logic [CLK_W-1:0] clock_frequency_q;
	logic [DIV_W-1:0] clock_divisor_q;
	logic             wr_en;
	cmd_t             cmd;
	status_t          status;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_frequency_q <= CLK_RESET;
			clock_divisor_q   <= DIV_RESET;
		end else if (wr_en) begin
			unique case (32'(paddr[2]))
				REG_CLOCK_FREQUENCY: clock_frequency_q <= pwdata[CLK_W-1:0];
				REG_CLOCK_DIVISOR:   clock_divisor_q   <= pwdata[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (32'(paddr[2]))
			REG_CLOCK_FREQUENCY: prdata = 32'(clock_frequency_q);
			REG_CLOCK_DIVISOR:   prdata = 32'(clock_divisor_q);
			default:             prdata = '0;
		endcase
	end

	cbts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
	);

	cbts_datapath #(
		.MAX_QUANTA(MAX_QUANTA), .MIN_QUANTA(MIN_QUANTA), .MAX_PRESCALER(MAX_PRESCALER)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.clock_frequency(clock_frequency_q), .clock_divisor(clock_divisor_q),
		.wished_rate(wished_rate), .tolerance_ppm(tolerance_ppm),
		.cmd(cmd), .status(status),
		.prescaler(prescaler), .prop_segment(prop_segment), .phase_one(phase_one),
		.phase_two(phase_two), .jump_width(jump_width), .triple_sample(triple_sample),
		.within_tolerance(within_tolerance), .actual_rate(actual_rate),
		.exact_match(exact_match), .ppm_error(ppm_error),
		.sample_point_pct(sample_point_pct), .consistency_flags(consistency_flags)
	);

`ifndef NO_ASSERTIONS
	// Once a beat is taken the sequencer is busy and takes no further beat.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again straight after an accepted beat");

	// The result register is only loaded when its previous beat has left.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !cmd.load_out)
		else $error("pending result overwritten");

	// The jump width never exceeds the second phase segment.
	a_rjw_fits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, jump_width} <= phase_two) && !consistency_flags[11])
		else $error("jump width beyond phase segment 2");
`endif

endmodule

// ===== hdl/cbts_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle, product wraps at 64 bits.
// Depends on cbts_pkg.
`timescale 1ns / 1ps

module cbts_mul
	import cbts_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ACC_W-1:0]   a,
	input  logic [MUL_B_W-1:0] b,
	output logic [ACC_W-1:0]   prod,
	output logic               done
);

	logic                 busy_q, done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0]     a_q, acc_q;
	logic [MUL_B_W-1:0]   b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(MUL_B_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) busy_q <= 1'b0;
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[ACC_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[MUL_B_W-1:1]};
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

// ===== hdl/cbts_div.sv =====
// Restoring divider, one quotient bit per cycle; the numerator arrives left-aligned.
// A zero divisor yields ones in every quotient bit computed. Depends on cbts_pkg.
`timescale 1ns / 1ps

module cbts_div
	import cbts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [ACC_W-1:0]     num,
	input  logic [ACC_W-1:0]     den,
	input  logic [DIV_CNT_W-1:0] iters,
	output logic [ACC_W-1:0]     quot,
	output logic [ACC_W-1:0]     rem,
	output logic                 done
);

	logic                 busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0]     num_q, den_q, rem_q, quot_q;
	logic [ACC_W:0]       trial, diff;
	logic                 ge;

	assign trial = {rem_q, num_q[ACC_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters - 1'b1;
			end else if (busy_q) begin
				if (cnt_q == '0) busy_q <= 1'b0;
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[ACC_W-2:0], 1'b0};
			rem_q  <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
			quot_q <= {quot_q[ACC_W-2:0], ge};
		end
	end

	assign quot = quot_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

// ===== hdl/cbts_datapath.sv =====
// Datapath of the solver: operand registers, search bookkeeping, segment split and
// result register, around one shared multiplier and one shared divider.
// Depends on cbts_pkg, cbts_mul and cbts_div.
`timescale 1ns / 1ps

module cbts_datapath
	import cbts_pkg::*;
#(
	parameter int unsigned MAX_QUANTA    = MAX_QUANTA_DEF,
	parameter int unsigned MIN_QUANTA    = MIN_QUANTA_DEF,
	parameter int unsigned MAX_PRESCALER = MAX_PRESCALER_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CLK_W-1:0]  clock_frequency,
	input  logic [DIV_W-1:0]  clock_divisor,
	input  logic [RATE_W-1:0] wished_rate,
	input  logic [TOL_W-1:0]  tolerance_ppm,
	input  cmd_t              cmd,
	output status_t           status,
	output logic [8:0]        prescaler,
	output logic [3:0]        prop_segment,
	output logic [3:0]        phase_one,
	output logic [3:0]        phase_two,
	output logic [2:0]        jump_width,
	output logic              triple_sample,
	output logic              within_tolerance,
	output logic [25:0]       actual_rate,
	output logic              exact_match,
	output logic [31:0]       ppm_error,
	output logic [6:0]        sample_point_pct,
	output logic [11:0]       consistency_flags
);

	localparam int unsigned PW    = $clog2(MAX_PRESCALER + 1);
	localparam int unsigned DVPW  = DIV_W + PW;
	localparam int unsigned DVPTW = DVPW + TQ_W;

	op_t                 op_q;
	logic [RATE_W-1:0]   rate_q;
	logic [TOL_W-1:0]    tol_q;
	logic [DR_W-1:0]     dr_q;
	logic [D_W-1:0]      d_q, best_d_q, r_q;
	logic [TQ_W-1:0]     t_q, best_t_q;
	logic [PW-1:0]       best_p_q;
	logic [D_W:0]        best_e_q;
	logic                have_q;
	logic [CLK_W-1:0]    q_q;
	logic [ACC_W-1:0]    w_q, lhs_q, rhs_q, wdv_q;
	logic [DVPW-1:0]     dvp_q;
	logic [DVPTW-1:0]    dvpt_q;
	logic [25:0]         act_q;
	logic [31:0]         ppm_q;
	logic [6:0]          sp_q;

	logic                 mul_start, div_start, mul_done, div_done;
	logic [ACC_W-1:0]     mul_a, mul_prod, div_num, div_den, div_quot, div_rem;
	logic [MUL_B_W-1:0]   mul_b;
	logic [DIV_CNT_W-1:0] div_iters;
	logic [ACC_W-1:0]     clk_ext, diff;

	// Search candidates, floor first, then floor plus one.
	logic           q_gt, take1, take2, have1;
	logic [D_W:0]   e1, e2, eb1;
	logic [PW-1:0]  pb1;

	// Segment split of the chosen quanta count.
	logic [TQ_W-1:0]    ps2, rest, ps1, prop, rjw, sp_base;
	logic               trip;
	logic [SPNUM_W-1:0] sp_num;
	logic [11:0]        flags;

	assign clk_ext = ACC_W'(clock_frequency);
	assign diff    = (clk_ext > w_q) ? clk_ext - w_q : w_q - clk_ext;

	assign mul_start = cmd.start && !is_div_op(cmd.op);
	assign div_start = cmd.start && is_div_op(cmd.op);

	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_num   = {clock_frequency, {(ACC_W - CLK_W){1'b0}}};
		div_den   = ACC_W'(d_q);
		div_iters = ITER_CLK;
		case (cmd.op)
			OP_DR:   begin mul_a = ACC_W'(rate_q);   mul_b = MUL_B_W'(clock_divisor); end
			OP_D0:   begin mul_a = ACC_W'(dr_q);     mul_b = MUL_B_W'(MAX_QUANTA); end
			OP_W:    begin mul_a = ACC_W'(best_d_q); mul_b = MUL_B_W'(best_p_q); end
			OP_LHS:  begin mul_a = diff;             mul_b = PPM_SCALE; end
			OP_RHS:  begin mul_a = w_q;              mul_b = MUL_B_W'(tol_q); end
			OP_WDV:  begin mul_a = w_q;              mul_b = MUL_B_W'(clock_divisor); end
			OP_DVP:  begin mul_a = ACC_W'(clock_divisor); mul_b = MUL_B_W'(best_p_q); end
			OP_DVPT: begin mul_a = ACC_W'(dvp_q);    mul_b = MUL_B_W'(best_t_q); end
			OP_ACT:  div_den = ACC_W'(dvpt_q);
			OP_PPM:  begin
				div_num   = lhs_q;
				div_den   = wdv_q;
				div_iters = ITER_PPM;
			end
			OP_SP:   begin
				div_num   = {sp_num, {(ACC_W - SPNUM_W){1'b0}}};
				div_den   = ACC_W'(best_t_q);
				div_iters = ITER_SP;
			end
			default: ;
		endcase
	end

	cbts_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.prod(mul_prod), .done(mul_done)
	);

	cbts_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.iters(div_iters), .quot(div_quot), .rem(div_rem), .done(div_done)
	);

	always_comb begin
		q_gt  = 32'(q_q) > 32'(MAX_PRESCALER);
		e1    = {1'b0, r_q};
		e2    = {1'b0, d_q - r_q};
		take1 = (q_q != '0) && (!have_q || e1 < best_e_q);
		have1 = have_q || take1;
		eb1   = take1 ? e1 : best_e_q;
		pb1   = take1 ? q_q[PW-1:0] : best_p_q;
		take2 = (32'(q_q) < 32'(MAX_PRESCALER)) && (!have1 || e2 < eb1);
	end

	assign status.done = mul_done || div_done;
	assign status.stop = q_gt || (t_q == TQ_W'(MIN_QUANTA));

	always_comb begin
		ps2     = 5'd1 + div7({best_t_q, 1'b0});
		rest    = best_t_q - ps2 - 5'd1;
		ps1     = {1'b0, rest[TQ_W-1:1]};
		prop    = rest - ps1;
		rjw     = (ps2 >= RJW_LIMIT) ? RJW_LIMIT : ps2;
		trip    = (rate_q <= TRIPLE_RATE_MAX) && (ps1 >= 5'd2);
		sp_base = 5'd1 + prop + ps1 - TQ_W'(trip);
		sp_num  = (SPNUM_W'(sp_base) << 6) + (SPNUM_W'(sp_base) << 5) +
			(SPNUM_W'(sp_base) << 2);
		flags     = '0;
		flags[0]  = best_p_q == '0;
		flags[1]  = (best_p_q != '0) && (32'(best_p_q) > 32'(PSC_LIMIT));
		flags[2]  = prop == '0;
		flags[3]  = (prop != '0) && (prop > SEG_LIMIT);
		flags[4]  = ps1 == '0;
		flags[5]  = (ps1 == 5'd1) && trip;
		flags[6]  = (ps1 > SEG_LIMIT);
		flags[7]  = ps2 == '0;
		flags[8]  = (ps2 != '0) && (ps2 > SEG_LIMIT);
		flags[9]  = rjw == '0;
		flags[10] = (rjw != '0) && (rjw > RJW_LIMIT);
		flags[11] = rjw > ps2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			op_q   <= OP_DR;
		end else begin
			if (cmd.start) op_q <= cmd.op;
			if (cmd.load_in) have_q <= 1'b0;
			else if (cmd.check && !q_gt) have_q <= have1 || take2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			rate_q   <= wished_rate;
			tol_q    <= tolerance_ppm;
			t_q      <= TQ_W'(MAX_QUANTA);
			best_t_q <= TQ_W'(MAX_QUANTA);
			best_p_q <= PW'(MAX_PRESCALER);
			best_e_q <= '0;
		end
		if (mul_done) begin
			case (op_q)
				OP_DR:   dr_q <= mul_prod[DR_W-1:0];
				OP_D0:   begin
					d_q      <= mul_prod[D_W-1:0];
					best_d_q <= mul_prod[D_W-1:0];
				end
				OP_W:    w_q    <= mul_prod;
				OP_LHS:  lhs_q  <= mul_prod;
				OP_RHS:  rhs_q  <= mul_prod;
				OP_WDV:  wdv_q  <= mul_prod;
				OP_DVP:  dvp_q  <= mul_prod[DVPW-1:0];
				OP_DVPT: dvpt_q <= mul_prod[DVPTW-1:0];
				default: ;
			endcase
		end
		if (div_done) begin
			case (op_q)
				OP_SRCH: begin
					q_q <= div_quot[CLK_W-1:0];
					r_q <= div_rem[D_W-1:0];
				end
				OP_ACT:  act_q <= div_quot[25:0];
				OP_PPM:  ppm_q <= div_quot[31:0];
				OP_SP:   sp_q  <= div_quot[6:0];
				default: ;
			endcase
		end
		if (cmd.check && !q_gt) begin
			if (take1 || take2) begin
				best_t_q <= t_q;
				best_d_q <= d_q;
			end
			if (take2) begin
				best_e_q <= e2;
				best_p_q <= q_q[PW-1:0] + 1'b1;
			end else begin
				best_e_q <= eb1;
				best_p_q <= pb1;
			end
			if (t_q != TQ_W'(MIN_QUANTA)) begin
				t_q <= t_q - 1'b1;
				d_q <= d_q - D_W'(dr_q);
			end
		end
		if (cmd.load_out) begin
			prescaler         <= 9'(best_p_q);
			prop_segment      <= prop[3:0];
			phase_one         <= ps1[3:0];
			phase_two         <= ps2[3:0];
			jump_width        <= rjw[2:0];
			triple_sample     <= trip;
			within_tolerance  <= lhs_q <= rhs_q;
			actual_rate       <= act_q;
			exact_match       <= clk_ext == w_q;
			ppm_error         <= ppm_q;
			sample_point_pct  <= sp_q;
			consistency_flags <= flags;
		end
	end

endmodule

// ===== hdl/cbts_ctrl.sv =====
// Controller of the solver: sequences the datapath operations and owns the
// input and output handshakes. Depends on cbts_pkg.
`timescale 1ns / 1ps

module cbts_ctrl
	import cbts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_DR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			op_q        <= op_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		cmd         = '0;
		cmd.op      = op_q;
		in_stall    = 1'b1;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					op_d        = OP_DR;
					state_d     = ST_GO;
				end
			end
			ST_GO: begin
				cmd.start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (status.done) begin
					if (op_q == OP_SRCH) begin
						state_d = ST_CHECK;
					end else if (op_q == OP_SP) begin
						state_d = ST_DONE;
					end else begin
						op_d    = next_op(op_q);
						state_d = ST_GO;
					end
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				op_d      = status.stop ? OP_W : OP_SRCH;
				state_d   = ST_GO;
			end
			ST_DONE: begin
				// The result register is reused only once the previous beat has gone.
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
